// ===== design/vdim_pkg.sv =====
// Package for the vertex deduplication index map.
// Holds table sizing constants, channel payload types, controller states
// and the command and status bundles between controller and datapath.
package vdim_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int FIELD_W       = 16;
    localparam int KEY_W         = 3 * FIELD_W;
    localparam int VIDX_W        = 10;

    typedef struct packed {
        logic               starts_chunk;
        logic [FIELD_W-1:0] position_index;
        logic [FIELD_W-1:0] texcoord_index;
        logic [FIELD_W-1:0] normal_index;
    } t_in_item;

    typedef struct packed {
        logic [VIDX_W-1:0] vertex_index;
        logic              is_new;
        logic              table_full;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic latch;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic miss;
        logic out_free;
    } t_sts;

endpackage

// ===== design/vdim_ctrl.sv =====
// Controller for the vertex deduplication index map.
// Sequences load, table scan, result latch and commit; uses vdim_pkg.
module vdim_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  vdim_pkg::t_sts i_sts,
    output logic           o_in_stall,
    output vdim_pkg::t_cmd o_cmd
);

    vdim_pkg::t_state r_state;
    vdim_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vdim_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        unique case (r_state)
            vdim_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = vdim_pkg::S_SEARCH;
                end
            end
            vdim_pkg::S_SEARCH: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit || i_sts.miss) begin
                    o_cmd.latch = 1'b1;
                    n_state     = vdim_pkg::S_DONE;
                end
            end
            vdim_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = vdim_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vdim_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/vdim_dpath.sv =====
// Datapath for the vertex deduplication index map.
// Holds the key memory, entry count, scan pointer and output register; uses vdim_pkg.
module vdim_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vdim_pkg::t_in_item  i_in_data,
    input  vdim_pkg::t_cmd      i_cmd,
    input  logic                i_out_stall,
    output vdim_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    output vdim_pkg::t_out_item o_out_data
);

    logic [vdim_pkg::KEY_W-1:0]  r_mem [vdim_pkg::TABLE_ENTRIES];
    logic [vdim_pkg::KEY_W-1:0]  r_key;
    logic [vdim_pkg::CNT_W-1:0]  r_count;
    logic [vdim_pkg::CNT_W-1:0]  r_scan;
    logic [vdim_pkg::KEY_W-1:0]  r_rd_key;
    logic [vdim_pkg::ADDR_W-1:0] r_rd_idx;
    logic                        r_rd_vld;
    logic                        r_found;
    logic [vdim_pkg::ADDR_W-1:0] r_found_idx;
    logic                        r_out_vld;
    vdim_pkg::t_out_item         r_out;

    logic                        scan_done;
    logic                        issue;
    logic                        full;
    logic                        store;
    logic [vdim_pkg::ADDR_W-1:0] res_idx;
    logic [vdim_pkg::VIDX_W+vdim_pkg::ADDR_W-1:0] res_wide;

    assign scan_done = (r_scan >= r_count);
    assign issue     = i_cmd.scan && !scan_done;
    assign full      = (r_count == vdim_pkg::CNT_W'(vdim_pkg::TABLE_ENTRIES));
    assign store     = i_cmd.commit && !r_found && !full;
    assign res_idx   = r_found ? r_found_idx : r_count[vdim_pkg::ADDR_W-1:0];
    assign res_wide  = {{vdim_pkg::VIDX_W{1'b0}}, res_idx};

    assign o_sts.hit      = r_rd_vld && (r_rd_key == r_key);
    assign o_sts.miss     = !r_rd_vld && scan_done;
    assign o_sts.out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mem[r_count[vdim_pkg::ADDR_W-1:0]] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_key <= r_mem[r_scan[vdim_pkg::ADDR_W-1:0]];
            r_rd_idx <= r_scan[vdim_pkg::ADDR_W-1:0];
        end
        if (i_cmd.load) begin
            r_key <= {i_in_data.position_index, i_in_data.texcoord_index,
                      i_in_data.normal_index};
        end
        if (i_cmd.latch) begin
            r_found     <= o_sts.hit;
            r_found_idx <= r_rd_idx;
        end
        if (i_cmd.commit) begin
            r_out.vertex_index <= (!r_found && full) ? '0 : res_wide[vdim_pkg::VIDX_W-1:0];
            r_out.is_new       <= store;
            r_out.table_full   <= !r_found && full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_scan    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_scan   <= '0;
                r_rd_vld <= 1'b0;
                if (i_in_data.starts_chunk) begin
                    r_count <= '0;
                end
            end else begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_scan <= r_scan + 1'b1;
                end
            end
            if (store) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== design/vertex_dedup_index_map.sv =====
// Vertex deduplication index map: one face vertex triple in, one vertex index out.
// A triple already seen in the current chunk returns its stored index; a new triple
// gets the next index, or index 0 with table_full set once the table is full. The key
// memory has one read port, so the lookup reads the stored entries one per cycle.
// A lookup accepts the item, reads the entries up to the match, compares and commits;
// a miss is flagged only after the last stored entry has been compared. The result
// sits in an output register, so the next item is accepted while it waits; a stalled
// result holds the commit of that next item. Uses vdim_pkg, vdim_ctrl and vdim_dpath.
module vertex_dedup_index_map (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  vdim_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output vdim_pkg::t_out_item o_out_data
);

    vdim_pkg::t_cmd cmd;
    vdim_pkg::t_sts sts;

    vdim_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    vdim_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/sv/vertex_dedup_index_map_tb.sv =====
// Self-checking testbench for vertex_dedup_index_map: directed corner vertices, small random
// chunks under four idle mixes, and one chunk that fills the table and overflows it.
// Depends on vdim_pkg and the vertex_dedup_index_map RTL.
module vertex_dedup_index_map_tb;

    localparam int FIELD_W       = vdim_pkg::FIELD_W;
    localparam int KEY_W         = vdim_pkg::KEY_W;
    localparam int VIDX_W        = vdim_pkg::VIDX_W;
    localparam int TABLE_ENTRIES = vdim_pkg::TABLE_ENTRIES;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SMALL_PHASE_ITEMS = 10;
    localparam logic [FIELD_W-1:0] FMAX = '1;
    localparam logic [FIELD_W-1:0] FZERO = '0;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    vdim_pkg::t_in_item  in_data;
    logic                out_valid;
    logic                out_stall;
    vdim_pkg::t_out_item out_data;

    vdim_pkg::t_in_item  pending_vertices[$];
    vdim_pkg::t_out_item expected_indices[$];

    int unsigned slot_of_key[logic [KEY_W-1:0]];
    int unsigned stored_count;

    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int error_count;
    int checked_count;
    int chunk_count;
    int new_count;
    int full_count;

    vertex_dedup_index_map dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    function automatic vdim_pkg::t_out_item predict_vertex(input vdim_pkg::t_in_item v);
        logic [KEY_W-1:0]    key;
        vdim_pkg::t_out_item r;
        key = {v.position_index, v.texcoord_index, v.normal_index};
        r = '0;
        if (v.starts_chunk) begin
            slot_of_key.delete();
            stored_count = 0;
        end
        if (slot_of_key.exists(key)) begin
            r.vertex_index = VIDX_W'(slot_of_key[key]);
        end else if (stored_count >= TABLE_ENTRIES) begin
            r.table_full = 1'b1;
        end else begin
            slot_of_key[key] = stored_count;
            r.vertex_index = VIDX_W'(stored_count);
            r.is_new = 1'b1;
            stored_count++;
        end
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] random_field();
        case ($urandom_range(9))
            0, 1: return FIELD_W'($urandom_range(3));
            2, 3: return FMAX - FIELD_W'($urandom_range(3));
            4: return FIELD_W'(1) << $urandom_range(FIELD_W - 1);
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    task automatic queue_vertex(input vdim_pkg::t_in_item v);
        pending_vertices = {pending_vertices, v};
    endtask

    task automatic wait_drained();
        while (pending_vertices.size() != 0 || in_valid || expected_indices.size() != 0) begin
            @(negedge clk);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_indices = {expected_indices, predict_vertex(in_data)};
                if (in_data.starts_chunk) begin
                    chunk_count++;
                end
            end
            if (!in_valid || !in_stall) begin
                if (pending_vertices.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_data  <= pending_vertices.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        vdim_pkg::t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
            if (out_valid && !out_stall) begin
                if (expected_indices.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, out_data);
                    error_count++;
                end else begin
                    want = expected_indices.pop_front();
                    checked_count++;
                    new_count += want.is_new;
                    full_count += want.table_full;
                    if (out_data.vertex_index !== want.vertex_index) begin
                        $display("%0t: vertex_index expected %0d, got %0d", $time,
                                 want.vertex_index, out_data.vertex_index);
                        error_count++;
                    end
                    if (out_data.is_new !== want.is_new) begin
                        $display("%0t: is_new expected %0b, got %0b", $time,
                                 want.is_new, out_data.is_new);
                        error_count++;
                    end
                    if (out_data.table_full !== want.table_full) begin
                        $display("%0t: table_full expected %0b, got %0b", $time,
                                 want.table_full, out_data.table_full);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] chunk_keys[$];
        logic [KEY_W-1:0] prev_keys[$];
        logic [KEY_W-1:0] fill_keys[$];
        bit               fill_seen[logic [KEY_W-1:0]];
        bit               starts;
        int               ph;
        int               n;
        int               k;
        int               chunk_len;
        int               pick;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stored_count = 0;
        error_count = 0;
        checked_count = 0;
        chunk_count = 0;
        new_count = 0;
        full_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // field extremes, single-field near misses, stale keys after a chunk start
        queue_vertex(vdim_pkg::t_in_item'{1'b1, FZERO, FZERO, FZERO});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FZERO, FZERO, FZERO});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FMAX, FMAX, FMAX});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FMAX, FZERO, FZERO});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FZERO, FMAX, FZERO});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FZERO, FZERO, FMAX});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FZERO, FMAX, FMAX});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FMAX, FMAX, FMAX - 16'd1});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FMAX >> 1, FMAX, FMAX});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FMAX, FMAX, FMAX});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FMAX, FZERO, FZERO});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FZERO, FZERO, FMAX});
        queue_vertex(vdim_pkg::t_in_item'{1'b1, FMAX, FMAX, FMAX});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FZERO, FZERO, FZERO});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FMAX, FZERO, FZERO});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FZERO, FMAX, FMAX});
        queue_vertex(vdim_pkg::t_in_item'{1'b1, FZERO, FZERO, FZERO});
        queue_vertex(vdim_pkg::t_in_item'{1'b1, FZERO, FZERO, FZERO});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, FZERO, FZERO, FZERO});
        queue_vertex(vdim_pkg::t_in_item'{1'b0, 16'h1234, 16'h5678, 16'h9abc});
        wait_drained();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 45;
                end
                default: begin
                    send_idle_pct = 15;
                    recv_stall_pct = 15;
                end
            endcase
            n = 0;
            while (n < SMALL_PHASE_ITEMS) begin
                chunk_len = $urandom_range(4, 48);
                for (k = 0; k < chunk_len && n < SMALL_PHASE_ITEMS; k++) begin
                    pick = $urandom_range(99);
                    if (chunk_keys.size() != 0 && pick < 50) begin
                        key = chunk_keys[$urandom_range(chunk_keys.size() - 1)];
                    end else if (prev_keys.size() != 0 && pick < 62) begin
                        key = prev_keys[$urandom_range(prev_keys.size() - 1)];
                    end else if (chunk_keys.size() != 0 && pick < 75) begin
                        key = chunk_keys[$urandom_range(chunk_keys.size() - 1)]
                              ^ (KEY_W'(1) << $urandom_range(KEY_W - 1));
                    end else begin
                        key = {random_field(), random_field(), random_field()};
                    end
                    starts = (k == 0) || ($urandom_range(99) < 3);
                    if (starts) begin
                        prev_keys = chunk_keys;
                        chunk_keys.delete();
                    end
                    chunk_keys = {chunk_keys, key};
                    queue_vertex(vdim_pkg::t_in_item'({starts, key}));
                    n++;
                end
            end
            wait_drained();
        end

        // fill the whole table, then overflow it
        send_idle_pct = 15;
        recv_stall_pct = 15;
        for (k = 0; k < TABLE_ENTRIES; k++) begin
            do key = {random_field(), random_field(), random_field()};
            while (fill_seen.exists(key));
            fill_seen[key] = 1'b1;
            fill_keys = {fill_keys, key};
            queue_vertex(vdim_pkg::t_in_item'({k == 0, key}));
            if (k % 97 == 50) begin
                key = fill_keys[$urandom_range(fill_keys.size() - 1)];
                queue_vertex(vdim_pkg::t_in_item'({1'b0, key}));
            end
        end
        for (k = 0; k < 24; k++) begin
            case (k % 4)
                0: key = fill_keys[(k % 8 == 0) ? 0 : TABLE_ENTRIES - 1];
                1: begin
                    do key = {random_field(), random_field(), random_field()};
                    while (fill_seen.exists(key));
                end
                2: begin
                    do key = fill_keys[$urandom_range(TABLE_ENTRIES - 1)]
                             ^ (KEY_W'(1) << $urandom_range(KEY_W - 1));
                    while (fill_seen.exists(key));
                end
                default: key = fill_keys[$urandom_range(TABLE_ENTRIES - 1)];
            endcase
            queue_vertex(vdim_pkg::t_in_item'({1'b0, key}));
        end
        queue_vertex(vdim_pkg::t_in_item'({1'b1, fill_keys[TABLE_ENTRIES - 1]}));
        queue_vertex(vdim_pkg::t_in_item'({1'b0, fill_keys[TABLE_ENTRIES - 1]}));
        wait_drained();

        repeat (TABLE_ENTRIES + 3) @(negedge clk);
        $display("Checked %0d vertex results over %0d chunks: %0d new, %0d refused as full",
                 checked_count, chunk_count, new_count, full_count);
        $display("Idle mixes covered: none, sender, receiver, both; one chunk filled all %0d",
                 TABLE_ENTRIES);
        if (error_count == 0 && expected_indices.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d errors, %0d results never seen", error_count,
                     expected_indices.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/vdim_pkg.sv
design/vdim_ctrl.sv
design/vdim_dpath.sv
design/vertex_dedup_index_map.sv
tb/sv/vertex_dedup_index_map_tb.sv
